FILE: rtl/core/npc_pkg.sv
`default_nettype none

package npc_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int STORE_DEPTH     = 256;
  localparam int IDX_W           = 8;
  localparam int CH_W            = 8;
  localparam int ENTRY_W         = 3 * CH_W;
  localparam int SQ_W            = 2 * CH_W;
  localparam int DIST_W          = SQ_W + 2;

  localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(PALETTE_ENTRIES - 1);
  localparam logic [IDX_W:0]    ENTRY_LIM  = (IDX_W + 1)'(PALETTE_ENTRIES);
  localparam logic [DIST_W-1:0] DIST_INIT  = {DIST_W{1'b1}};

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_WRITE  = 1'b1;

  localparam logic ORDER_LOW_FIRST = 1'b0;
  localparam logic ORDER_HIGH_FIRST = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  typedef struct packed {
    logic             v;
    logic [IDX_W-1:0] idx;
  } tag_t;

endpackage

`default_nettype wire

FILE: rtl/core/npc_palette_mem.sv
`default_nettype none

module npc_palette_mem (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        wr_en,
  input  wire logic [npc_pkg::IDX_W-1:0]   wr_addr,
  input  wire logic [npc_pkg::ENTRY_W-1:0] wr_data,
  input  wire logic                        rd_en,
  input  wire logic [npc_pkg::IDX_W-1:0]   rd_addr,
  output      logic [npc_pkg::ENTRY_W-1:0] rd_data,
  output      npc_pkg::tag_t               rd_tag
);

  logic [npc_pkg::ENTRY_W-1:0] mem [npc_pkg::STORE_DEPTH];
  logic [npc_pkg::STORE_DEPTH-1:0] vld_r;
  logic [npc_pkg::ENTRY_W-1:0] rd_data_r;
  logic                        rd_vld_r;
  npc_pkg::tag_t               rd_tag_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      rd_tag_r <= '0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r     <= vld_r[rd_addr];
      rd_tag_r.v   <= rd_en;
      rd_tag_r.idx <= rd_addr;
    end
  end

  // never-written entries read as black
  assign rd_data = rd_vld_r ? rd_data_r : '0;
  assign rd_tag  = rd_tag_r;

endmodule

`default_nettype wire

FILE: rtl/core/npc_dist.sv
`default_nettype none

module npc_dist (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [npc_pkg::CH_W-1:0]    px_red,
  input  wire logic [npc_pkg::CH_W-1:0]    px_green,
  input  wire logic [npc_pkg::CH_W-1:0]    px_blue,
  input  wire logic [npc_pkg::ENTRY_W-1:0] entry,
  input  wire npc_pkg::tag_t               tag_in,
  output      logic [npc_pkg::DIST_W-1:0]  dist_sum,
  output      npc_pkg::tag_t               tag_out
);

  localparam int CW = npc_pkg::CH_W;
  localparam int SW = npc_pkg::SQ_W;
  localparam int DW = npc_pkg::DIST_W;

  logic [CW-1:0] e_red, e_green, e_blue;
  logic [CW-1:0] d_red, d_green, d_blue;
  logic [SW-1:0] sq_red_r, sq_green_r, sq_blue_r;
  npc_pkg::tag_t tag_r;

  assign e_red   = entry[3*CW-1:2*CW];
  assign e_green = entry[2*CW-1:CW];
  assign e_blue  = entry[CW-1:0];

  assign d_red   = (px_red   > e_red)   ? px_red   - e_red   : e_red   - px_red;
  assign d_green = (px_green > e_green) ? px_green - e_green : e_green - px_green;
  assign d_blue  = (px_blue  > e_blue)  ? px_blue  - e_blue  : e_blue  - px_blue;

  always_ff @(posedge clk) begin
    sq_red_r   <= SW'(d_red)   * SW'(d_red);
    sq_green_r <= SW'(d_green) * SW'(d_green);
    sq_blue_r  <= SW'(d_blue)  * SW'(d_blue);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_in;
    end
  end

  assign dist_sum = DW'(sq_red_r) + DW'(sq_green_r) + DW'(sq_blue_r);
  assign tag_out  = tag_r;

endmodule

`default_nettype wire

FILE: rtl/core/nearest_palette_color.sv
// Channel  | Ports                                              | Handshake
// input    | in_mode, in_pixel_word, in_entry_index/red/green/blue | start & !busy
// result   | out_color_index                                    | out_valid, one cycle
// config   | cfg_channel_order                                  | cfg_valid & cfg_ready
//
// A palette write gives no result.
// A lookup reads one palette entry per cycle from the palette RAM port:
// up to 256 reads, through the read and square registers; an exact match
// ends the scan early. busy is high meanwhile.
// Reset clears the palette to black through per-entry valid flags, no sweep.
// The receiver cannot stall: out_valid is high for one cycle per lookup.
`default_nettype none

module nearest_palette_color (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic        in_mode,
  input  wire logic [31:0] in_pixel_word,
  input  wire logic [7:0]  in_entry_index,
  input  wire logic [7:0]  in_entry_red,
  input  wire logic [7:0]  in_entry_green,
  input  wire logic [7:0]  in_entry_blue,
  output      logic        out_valid,
  output      logic [7:0]  out_color_index,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic        cfg_channel_order
);

  localparam int CW = npc_pkg::CH_W;
  localparam int IW = npc_pkg::IDX_W;
  localparam int DW = npc_pkg::DIST_W;

  npc_pkg::state_t state_r, state_nxt;

  logic          order_r;
  logic [CW-1:0] px_red_r, px_green_r, px_blue_r;
  logic [IW-1:0] addr_r, addr_nxt;
  logic          issue_r, issue_nxt;
  logic [DW-1:0] best_dist_r, best_dist_nxt;
  logic [IW-1:0] best_idx_r, best_idx_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [IW-1:0] out_idx_r, out_idx_nxt;

  logic                        accept;
  logic                        lookup_go;
  logic                        wr_en;
  logic [npc_pkg::ENTRY_W-1:0] rd_data;
  npc_pkg::tag_t               rd_tag;
  npc_pkg::tag_t               dst_tag;
  logic [DW-1:0]               dist_sum;
  logic                        hit;
  logic                        exact;
  logic                        better;
  logic                        finish;
  logic [IW-1:0]               cand_idx;

  assign accept    = start && !busy;
  assign lookup_go = accept && (in_mode == npc_pkg::MODE_LOOKUP);
  assign wr_en     = accept && (in_mode == npc_pkg::MODE_WRITE)
                     && ({1'b0, in_entry_index} < npc_pkg::ENTRY_LIM);

  npc_palette_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (in_entry_index),
    .wr_data ({in_entry_red, in_entry_green, in_entry_blue}),
    .rd_en   (issue_r && (state_r == npc_pkg::ST_SCAN)),
    .rd_addr (addr_r),
    .rd_data (rd_data),
    .rd_tag  (rd_tag)
  );

  npc_dist u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .px_red   (px_red_r),
    .px_green (px_green_r),
    .px_blue  (px_blue_r),
    .entry    (rd_data),
    .tag_in   (rd_tag),
    .dist_sum (dist_sum),
    .tag_out  (dst_tag)
  );

  assign hit      = dst_tag.v && (state_r == npc_pkg::ST_SCAN);
  assign exact    = (dist_sum == '0);
  assign better   = dist_sum < best_dist_r;
  assign cand_idx = (exact || better) ? dst_tag.idx : best_idx_r;
  assign finish   = hit && (exact || (dst_tag.idx == npc_pkg::LAST_IDX));

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    issue_nxt     = issue_r;
    best_dist_nxt = best_dist_r;
    best_idx_nxt  = best_idx_r;
    out_valid_nxt = 1'b0;
    out_idx_nxt   = out_idx_r;
    unique case (state_r)
      npc_pkg::ST_IDLE: begin
        if (lookup_go) begin
          state_nxt     = npc_pkg::ST_SCAN;
          addr_nxt      = '0;
          issue_nxt     = 1'b1;
          best_dist_nxt = npc_pkg::DIST_INIT;
          best_idx_nxt  = '0;
        end
      end
      npc_pkg::ST_SCAN: begin
        if (issue_r) begin
          addr_nxt = addr_r + IW'(1);
          if (addr_r == npc_pkg::LAST_IDX) begin
            issue_nxt = 1'b0;
          end
        end
        if (hit && better) begin
          best_dist_nxt = dist_sum;
          best_idx_nxt  = dst_tag.idx;
        end
        if (finish) begin
          state_nxt     = npc_pkg::ST_DRAIN;
          issue_nxt     = 1'b0;
          out_valid_nxt = 1'b1;
          out_idx_nxt   = cand_idx;
        end
      end
      npc_pkg::ST_DRAIN: begin
        // drop reads still in flight after an early exit
        if (!rd_tag.v && !dst_tag.v) begin
          state_nxt = npc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = npc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= npc_pkg::ST_IDLE;
      issue_r     <= 1'b0;
      out_valid_r <= 1'b0;
      order_r     <= npc_pkg::ORDER_LOW_FIRST;
    end else begin
      state_r     <= state_nxt;
      issue_r     <= issue_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        order_r <= cfg_channel_order;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    best_dist_r <= best_dist_nxt;
    best_idx_r  <= best_idx_nxt;
    out_idx_r   <= out_idx_nxt;
    if (lookup_go) begin
      if (order_r == npc_pkg::ORDER_HIGH_FIRST) begin
        px_red_r   <= in_pixel_word[31:24];
        px_green_r <= in_pixel_word[23:16];
        px_blue_r  <= in_pixel_word[15:8];
      end else begin
        px_red_r   <= in_pixel_word[7:0];
        px_green_r <= in_pixel_word[15:8];
        px_blue_r  <= in_pixel_word[23:16];
      end
    end
  end

  assign busy            = (state_r != npc_pkg::ST_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_color_index = out_idx_r;

  a_result_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == npc_pkg::ST_SCAN))
    else $error("result without a scan");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    lookup_go |=> busy)
    else $error("lookup accepted but block not busy");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_color_index <= npc_pkg::LAST_IDX))
    else $error("result index beyond palette");

endmodule

`default_nettype wire
